FILE: hw/rtl/cp437u_pkg.sv
package cp437u_pkg;

   localparam int ColumnDigits = 3;
   // a newline run must fit in the result buffer, so at most three digits
   localparam int EffDigits   = (ColumnDigits > 3) ? 3 : ((ColumnDigits < 1) ? 1 : ColumnDigits);
   localparam int ColumnLimit = (EffDigits == 1) ? 9 : ((EffDigits == 2) ? 99 : 999);

   localparam int MaxOut    = 8;
   localparam int CountW    = $clog2(MaxOut + 1);
   localparam int IdxW      = $clog2(MaxOut);
   localparam int ByteW     = 8;
   localparam int ColumnW   = 10;
   localparam int PageW     = 10;
   localparam int LineW     = 10;
   localparam int CsrIndexW = 2;
   localparam int CsrDataW  = 10;
   localparam int DigitW    = 4;
   localparam int NdigW     = 2;

   localparam logic [CsrIndexW-1:0] CSR_COLUMN_SHIFT  = 2'd0;
   localparam logic [CsrIndexW-1:0] CSR_SCROLL_ENABLE = 2'd1;
   localparam logic [CsrIndexW-1:0] CSR_PAGE_LINES    = 2'd2;

   localparam logic [ColumnW-1:0] COLUMN_RESET = 10'd0;
   localparam logic [PageW-1:0]   PAGE_RESET   = 10'd24;
   localparam logic [LineW-1:0]   LINE_MAX     = 10'd1023;

   localparam logic [ByteW-1:0] CH_NUL     = 8'h00;
   localparam logic [ByteW-1:0] CH_EOT     = 8'h04;
   localparam logic [ByteW-1:0] CH_LF      = 8'h0A;
   localparam logic [ByteW-1:0] CH_CR      = 8'h0D;
   localparam logic [ByteW-1:0] CH_SUB     = 8'h1A;
   localparam logic [ByteW-1:0] CH_ESC     = 8'h1B;
   localparam logic [ByteW-1:0] CH_LBRACK  = 8'h5B;
   localparam logic [ByteW-1:0] CH_ZERO    = 8'h30;
   localparam logic [ByteW-1:0] CH_FWD     = 8'h43;
   localparam logic [ByteW-1:0] CH_DEL     = 8'h7F;
   localparam logic [15:0]      GLYPH_HOUSE = 16'h2302;

   typedef struct packed {
      logic             mode;
      logic [ByteW-1:0] data_byte;
   } item_type;

   typedef struct packed {
      logic [MaxOut-1:0][ByteW-1:0] bytes;
      logic [CountW-1:0]            count;
      logic                         pause;
   } burst_type;

   localparam logic [15:0] LOW_GLYPHS [32] = '{
      16'h0000, 16'h263A, 16'h263B, 16'h2665, 16'h2666, 16'h2663, 16'h2660, 16'h2022,
      16'h25D8, 16'h25CB, 16'h25D9, 16'h2642, 16'h2640, 16'h266A, 16'h266B, 16'h263C,
      16'h25BA, 16'h25C4, 16'h2195, 16'h203C, 16'h00B6, 16'h00A7, 16'h25AC, 16'h21A8,
      16'h2191, 16'h2193, 16'h2192, 16'h2190, 16'h221F, 16'h2194, 16'h25B2, 16'h25BC
   };

   localparam logic [15:0] HIGH_GLYPHS [128] = '{
      16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
      16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
      16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
      16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
      16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
      16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
      16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
      16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
      16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
      16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
      16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
      16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580,
      16'h03B1, 16'h00DF, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
      16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h03C6, 16'h03B5, 16'h2229,
      16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
      16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h00A0
   };

   function automatic logic [15:0] glyph_of(input logic [ByteW-1:0] b);
      logic [15:0] g;
      if (b < 8'd32) begin
         g = LOW_GLYPHS[b[4:0]];
      end else if (b < CH_DEL) begin
         g = {8'h00, b};
      end else if (b == CH_DEL) begin
         g = GLYPH_HOUSE;
      end else begin
         g = HIGH_GLYPHS[b[6:0]];
      end
      return g;
   endfunction

endpackage

FILE: hw/rtl/cp437u_chan_if.sv
interface cp437u_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] data_byte;

   modport source (output valid, output mode, output data_byte, input ready);
   modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface cp437u_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;
   logic       pause_after;

   modport source (output valid, output out_byte, output last, output pause_after, input ready);
   modport sink   (input valid, input out_byte, input last, input pause_after, output ready);
endinterface

FILE: hw/rtl/cp437u_in_stage.sv
module cp437u_in_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  cp437u_pkg::item_type in_item,
   output logic                item_valid,
   output cp437u_pkg::item_type item,
   input  logic                consume
);
   import cp437u_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   // nothing is taken while reset is held
   assign in_ready   = !reset && (!valid_ff || consume);
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (consume) begin
         valid_in = 1'b0;
      end
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
         item_in  = in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end
endmodule

FILE: hw/rtl/cp437u_expand.sv
module cp437u_expand (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [cp437u_pkg::CsrIndexW-1:0]       csr_index,
   input  logic [cp437u_pkg::CsrDataW-1:0]        csr_wr_data,
   input  cp437u_pkg::item_type                   item,
   input  logic                                   advance,
   output cp437u_pkg::burst_type                  burst
);
   import cp437u_pkg::*;

   logic                 scroll_en_ff, scroll_en_in;
   logic [PageW-1:0]     page_ff, page_in;
   logic [DigitW-1:0]    dig_h_ff, dig_t_ff, dig_o_ff;
   logic [DigitW-1:0]    dig_h_in, dig_t_in, dig_o_in;
   logic [NdigW-1:0]     ndig_ff, ndig_in;
   logic [LineW-1:0]     lines_ff, lines_in;
   logic                 active_ff, active_in;
   logic                 stopped_ff, stopped_in;

   logic [ColumnW-1:0]   sat;
   logic [ColumnW-1:0]   rem_h;
   logic [6:0]           rem_t;
   logic [15:0]          cp;
   logic [LineW-1:0]     lines_inc;

   // column register is kept as decimal digits, decoded when written
   always_comb begin
      sat = (csr_wr_data > CsrDataW'(ColumnLimit)) ? CsrDataW'(ColumnLimit) : csr_wr_data;
      dig_h_in = '0;
      for (int k = 1; k < 10; k++) begin
         if (sat >= ColumnW'(k * 100)) dig_h_in = DigitW'(k);
      end
      rem_h = sat - ColumnW'(dig_h_in) * ColumnW'(100);
      dig_t_in = '0;
      for (int k = 1; k < 10; k++) begin
         if (rem_h[6:0] >= 7'(k * 10)) dig_t_in = DigitW'(k);
      end
      rem_t    = rem_h[6:0] - 7'(dig_t_in) * 7'd10;
      dig_o_in = rem_t[DigitW-1:0];
      if (sat >= ColumnW'(100)) begin
         ndig_in = 2'd3;
      end else if (sat >= ColumnW'(10)) begin
         ndig_in = 2'd2;
      end else begin
         ndig_in = 2'd1;
      end
   end

   always_comb begin
      scroll_en_in = scroll_en_ff;
      page_in      = page_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SCROLL_ENABLE: scroll_en_in = csr_wr_data[0];
            CSR_PAGE_LINES:    page_in      = csr_wr_data[PageW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cp         = glyph_of(item.data_byte);
      lines_inc  = (lines_ff < LINE_MAX) ? lines_ff + 1'b1 : lines_ff;
      lines_in   = lines_ff;
      active_in  = active_ff;
      stopped_in = stopped_ff;
      burst      = '0;
      if (item.mode) begin
         if (!stopped_ff) begin
            burst.bytes[0] = CH_CR;
            burst.bytes[1] = CH_LF;
            burst.count    = CountW'(2);
         end
         stopped_in = 1'b0;
      end else if (!stopped_ff) begin
         if (item.data_byte == CH_ESC) begin
            burst.bytes[0] = CH_ESC;
            burst.count    = CountW'(1);
         end else if (item.data_byte == CH_CR) begin
            burst.bytes[0] = CH_CR;
            burst.bytes[1] = CH_LF;
            burst.bytes[2] = CH_ESC;
            burst.bytes[3] = CH_LBRACK;
            case (ndig_ff)
               2'd3: begin
                  burst.bytes[4] = CH_ZERO | ByteW'(dig_h_ff);
                  burst.bytes[5] = CH_ZERO | ByteW'(dig_t_ff);
                  burst.bytes[6] = CH_ZERO | ByteW'(dig_o_ff);
                  burst.bytes[7] = CH_FWD;
               end
               2'd2: begin
                  burst.bytes[4] = CH_ZERO | ByteW'(dig_t_ff);
                  burst.bytes[5] = CH_ZERO | ByteW'(dig_o_ff);
                  burst.bytes[6] = CH_FWD;
               end
               default: begin
                  burst.bytes[4] = CH_ZERO | ByteW'(dig_o_ff);
                  burst.bytes[5] = CH_FWD;
               end
            endcase
            burst.count = CountW'(5) + CountW'(ndig_ff);
            if (scroll_en_ff) begin
               lines_in = lines_inc;
               if (lines_inc > page_ff) active_in = 1'b1;
               burst.pause = active_in;
            end
         end else if (item.data_byte == CH_SUB || item.data_byte == CH_EOT) begin
            burst.bytes[0] = CH_CR;
            burst.bytes[1] = CH_LF;
            burst.count    = CountW'(2);
            stopped_in     = 1'b1;
         end else if (item.data_byte != CH_NUL && item.data_byte != CH_LF) begin
            if (cp < 16'h0080) begin
               burst.bytes[0] = cp[7:0];
               burst.count    = CountW'(1);
            end else if (cp < 16'h0800) begin
               burst.bytes[0] = {3'b110, cp[10:6]};
               burst.bytes[1] = {2'b10, cp[5:0]};
               burst.count    = CountW'(2);
            end else begin
               burst.bytes[0] = {4'b1110, cp[15:12]};
               burst.bytes[1] = {2'b10, cp[11:6]};
               burst.bytes[2] = {2'b10, cp[5:0]};
               burst.count    = CountW'(3);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scroll_en_ff <= 1'b0;
         page_ff      <= PAGE_RESET;
         dig_h_ff     <= '0;
         dig_t_ff     <= '0;
         dig_o_ff     <= COLUMN_RESET[DigitW-1:0];
         ndig_ff      <= 2'd1;
         lines_ff     <= '0;
         active_ff    <= 1'b0;
         stopped_ff   <= 1'b0;
      end else begin
         scroll_en_ff <= scroll_en_in;
         page_ff      <= page_in;
         if (csr_wr_en && csr_index == CSR_COLUMN_SHIFT) begin
            dig_h_ff <= dig_h_in;
            dig_t_ff <= dig_t_in;
            dig_o_ff <= dig_o_in;
            ndig_ff  <= ndig_in;
         end
         if (advance) begin
            lines_ff   <= lines_in;
            active_ff  <= active_in;
            stopped_ff <= stopped_in;
         end
      end
   end
endmodule

FILE: hw/rtl/cp437u_out_stage.sv
module cp437u_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  cp437u_pkg::burst_type burst,
   input  logic                  load,
   output logic                  load_ok,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [7:0]            out_byte,
   output logic                  out_last,
   output logic                  out_pause
);
   import cp437u_pkg::*;

   burst_type         burst_ff;
   logic              valid_ff, valid_in;
   logic [IdxW-1:0]   idx_ff, idx_in;
   logic              fire;

   assign out_valid = valid_ff;
   assign out_byte  = burst_ff.bytes[idx_ff];
   assign out_last  = ({1'b0, idx_ff} == burst_ff.count - 1'b1);
   assign out_pause = out_last && burst_ff.pause;
   assign fire      = valid_ff && out_ready;
   // a fresh burst may enter as the final byte of the current one leaves
   assign load_ok   = !valid_ff || (fire && out_last);

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (fire) begin
         idx_in = idx_ff + 1'b1;
         if (out_last) valid_in = 1'b0;
      end
      if (load && burst.count != '0) begin
         valid_in = 1'b1;
         idx_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      if (load) begin
         burst_ff <= burst;
      end
   end
endmodule

FILE: hw/rtl/cp437_to_utf8_terminal_stream_unit.sv
// An input item passes the input register, then the expander, into the result register.
// Throughput: one result byte per cycle from the result register while the receiver is
// ready; an item yields 0 to 8 bytes (1 to 3 for glyphs), and items that yield nothing
// or one byte are taken every cycle unless the receiver stalls.
// Reset (synchronous): clears line count, scroll and stop flags, and restores
// the register defaults (column 0, scroll off, 24 lines per page).
module cp437_to_utf8_terminal_stream_unit (
   input  logic                              clock,
   input  logic                              reset,
   cp437u_req_if.sink                        req_chan,
   cp437u_rsp_if.source                      rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [cp437u_pkg::CsrIndexW-1:0]  csr_index,
   input  logic [cp437u_pkg::CsrDataW-1:0]   csr_wr_data
);
   import cp437u_pkg::*;

   item_type  in_item, item;
   burst_type burst;
   logic      item_valid, load_ok, consume;

   assign in_item.mode      = req_chan.mode;
   assign in_item.data_byte = req_chan.data_byte;
   assign consume           = item_valid && load_ok;

   cp437u_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_chan.valid),
      .in_ready   (req_chan.ready),
      .in_item    (in_item),
      .item_valid (item_valid),
      .item       (item),
      .consume    (consume)
   );

   cp437u_expand u_expand (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .item        (item),
      .advance     (consume),
      .burst       (burst)
   );

   cp437u_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .burst     (burst),
      .load      (consume),
      .load_ok   (load_ok),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_byte  (rsp_chan.out_byte),
      .out_last  (rsp_chan.last),
      .out_pause (rsp_chan.pause_after)
   );
endmodule

FILE: sim/tb_cp437_to_utf8_terminal_stream_unit.sv
`timescale 1ns / 1ps

module tb_cp437_to_utf8_terminal_stream_unit;
   import cp437u_pkg::*;

   localparam logic ModeText = 1'b0;
   localparam logic ModeEnd  = 1'b1;

   localparam int DigitCount = (ColumnDigits > 3) ? 3 : ((ColumnDigits < 1) ? 1 : ColumnDigits);
   localparam int ColumnTop  = (DigitCount == 1) ? 9 : ((DigitCount == 2) ? 99 : 999);
   localparam logic [9:0] LineTop = 10'd1023;

   localparam int HoldCycles = 200;
   localparam int QuietLimit = 3000;

   localparam logic [15:0] HouseGlyph = 16'h2302;

   localparam logic [15:0] LowGlyphs [32] = '{
      16'h0000, 16'h263A, 16'h263B, 16'h2665, 16'h2666, 16'h2663, 16'h2660, 16'h2022,
      16'h25D8, 16'h25CB, 16'h25D9, 16'h2642, 16'h2640, 16'h266A, 16'h266B, 16'h263C,
      16'h25BA, 16'h25C4, 16'h2195, 16'h203C, 16'h00B6, 16'h00A7, 16'h25AC, 16'h21A8,
      16'h2191, 16'h2193, 16'h2192, 16'h2190, 16'h221F, 16'h2194, 16'h25B2, 16'h25BC
   };

   localparam logic [15:0] HighGlyphs [128] = '{
      16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
      16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
      16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
      16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
      16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
      16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
      16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
      16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
      16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
      16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
      16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
      16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580,
      16'h03B1, 16'h00DF, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
      16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h03C6, 16'h03B5, 16'h2229,
      16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
      16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h00A0
   };

   localparam logic [9:0] ColumnMarks [8] = '{
      10'd0, 10'd9, 10'd10, 10'd99, 10'd100, 10'd999, 10'd1000, 10'd1023
   };

   // glyph widths, stop and restart, end of source with and without a stop
   localparam item_type Opening [19] = '{
      {ModeText, CH_NUL}, {ModeText, CH_LF},  {ModeText, 8'h41},  {ModeText, 8'h01},
      {ModeText, 8'h20},  {ModeText, CH_DEL}, {ModeText, 8'h80},  {ModeText, 8'h9E},
      {ModeText, 8'hFF},  {ModeText, CH_ESC}, {ModeText, CH_CR},  {ModeEnd, 8'hFF},
      {ModeText, CH_SUB}, {ModeText, 8'h41},  {ModeText, CH_CR},  {ModeEnd, 8'h00},
      {ModeText, CH_EOT}, {ModeEnd, 8'h5A},   {ModeEnd, 8'h00}
   };

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic       pause_after;
   } utf8_beat_type;

   class utf8_scoreboard;
      logic [9:0] column_shift;
      logic       scroll_on;
      logic [9:0] page_lines;
      logic [9:0] line_count;
      logic       scroll_flag;
      logic       stopped;
      utf8_beat_type utf8_expected [$];
      int         mismatches;

      function new();
         column_shift = COLUMN_RESET;
         scroll_on    = 1'b0;
         page_lines   = PAGE_RESET;
         line_count   = '0;
         scroll_flag  = 1'b0;
         stopped      = 1'b0;
         mismatches   = 0;
      endfunction

      function void set_config(logic [9:0] col, logic scroll, logic [9:0] page);
         column_shift = col;
         scroll_on    = scroll;
         page_lines   = page;
      endfunction

      function int pending();
         return utf8_expected.size();
      endfunction

      // work out the byte run for one accepted character and queue it
      function void take_char(logic mode, logic [7:0] b);
         logic [7:0] run [$];
         utf8_beat_type beat;
         logic [15:0] cp;
         int          v;
         bit          mark;
         mark = 1'b0;
         if (mode == ModeEnd) begin
            if (!stopped) begin
               run.push_back(CH_CR);
               run.push_back(CH_LF);
            end
            stopped = 1'b0;
         end else if (!stopped) begin
            if (b == CH_ESC) begin
               run.push_back(CH_ESC);
            end else if (b == CH_CR) begin
               v = (column_shift > ColumnTop) ? ColumnTop : int'(column_shift);
               run.push_back(CH_CR);
               run.push_back(CH_LF);
               run.push_back(CH_ESC);
               run.push_back(CH_LBRACK);
               if (v >= 100) run.push_back(CH_ZERO + 8'(v / 100));
               if (v >= 10) run.push_back(CH_ZERO + 8'((v / 10) % 10));
               run.push_back(CH_ZERO + 8'(v % 10));
               run.push_back(CH_FWD);
               if (scroll_on) begin
                  if (line_count != LineTop) line_count = line_count + 10'd1;
                  if (line_count > page_lines) scroll_flag = 1'b1;
                  mark = scroll_flag;
               end
            end else if (b == CH_SUB || b == CH_EOT) begin
               run.push_back(CH_CR);
               run.push_back(CH_LF);
               stopped = 1'b1;
            end else if (b != CH_NUL && b != CH_LF) begin
               if (b < 8'h20) cp = LowGlyphs[b[4:0]];
               else if (b < CH_DEL) cp = {8'h00, b};
               else if (b == CH_DEL) cp = HouseGlyph;
               else cp = HighGlyphs[b[6:0]];
               if (cp < 16'h0080) begin
                  run.push_back(cp[7:0]);
               end else if (cp < 16'h0800) begin
                  run.push_back({3'b110, cp[10:6]});
                  run.push_back({2'b10, cp[5:0]});
               end else begin
                  run.push_back({4'b1110, cp[15:12]});
                  run.push_back({2'b10, cp[11:6]});
                  run.push_back({2'b10, cp[5:0]});
               end
            end
         end
         foreach (run[k]) begin
            beat.out_byte    = run[k];
            beat.last        = (k == run.size() - 1);
            beat.pause_after = beat.last && mark;
            utf8_expected.push_back(beat);
         end
      endfunction

      task report(string msg);
         $display("%0t: mismatch: %s", $time, msg);
         mismatches++;
      endtask

      task check_byte(logic [7:0] b, logic last, logic pause);
         utf8_beat_type want;
         if (utf8_expected.size() == 0) begin
            report($sformatf("unexpected byte %02h", b));
            return;
         end
         want = utf8_expected.pop_front();
         if (b !== want.out_byte)
            report($sformatf("out_byte %02h, want %02h", b, want.out_byte));
         if (last !== want.last)
            report($sformatf("last %b, want %b (byte %02h)", last, want.last, b));
         if (pause !== want.pause_after)
            report($sformatf("pause_after %b, want %b (byte %02h)", pause, want.pause_after, b));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_wr_en;
   logic [CsrIndexW-1:0] csr_index;
   logic [CsrDataW-1:0]  csr_wr_data;

   cp437u_req_if req_chan ();
   cp437u_rsp_if rsp_chan ();

   cp437_to_utf8_terminal_stream_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   utf8_scoreboard sb;
   bit sender_steady   = 1'b0;
   bit receiver_steady = 1'b0;
   int stall_asks      = 0;
   int stall_taken     = 0;
   int quiet_cycles    = 0;
   bit moved;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // result first, then the new character: a result can never stem from the
   // transaction accepted at the same edge
   always @(posedge clock) begin
      if (!reset) begin
         moved = 1'b0;
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            sb.check_byte(rsp_chan.out_byte, rsp_chan.last, rsp_chan.pause_after);
            moved = 1'b1;
         end
         if (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) begin
            sb.take_char(req_chan.mode, req_chan.data_byte);
            moved = 1'b1;
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QuietLimit) begin
            $display("%0t: no transaction for %0d cycles", $time, QuietLimit);
            $display("tb_cp437_to_utf8_terminal_stream_unit: FAIL");
            $finish;
         end
      end
   end

   // receiver: random back-pressure, plus a long hold-off on request
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_taken != stall_asks) begin
            stall_taken = stall_asks;
            rsp_chan.ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
         end
         rsp_chan.ready <= receiver_steady || ($urandom_range(99) >= 36);
      end
   end

   task automatic send_char(input item_type it);
      while (!sender_steady && $urandom_range(99) < 36) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.mode      <= it.mode;
      req_chan.data_byte <= it.data_byte;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
   endtask

   // stop offering and wait for every queued byte, then a tail for items
   // still in flight that yield nothing
   task automatic drain(input int tail);
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (tail) @(posedge clock);
   endtask

   task automatic configure(input logic [9:0] col, input logic scroll, input logic [9:0] page);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_COLUMN_SHIFT;
      csr_wr_data <= col;
      @(posedge clock);
      csr_index   <= CSR_SCROLL_ENABLE;
      csr_wr_data <= {{(CsrDataW-1){1'b0}}, scroll};
      @(posedge clock);
      csr_index   <= CSR_PAGE_LINES;
      csr_wr_data <= page;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_config(col, scroll, page);
   endtask

   function automatic item_type random_char();
      int r;
      item_type it;
      r = $urandom_range(99);
      it.mode      = ModeText;
      it.data_byte = 8'($urandom_range(255));
      if (r < 22) it.data_byte = CH_CR;
      else if (r < 26) it.data_byte = r[0] ? CH_SUB : CH_EOT;
      else if (r < 31) it.mode = ModeEnd;
      else if (r < 35) it.data_byte = CH_ESC;
      else if (r < 39) it.data_byte = r[0] ? CH_NUL : CH_LF;
      return it;
   endfunction

   initial begin
      logic [9:0] col;
      logic [9:0] page;
      sb = new();
      req_chan.valid     = 1'b0;
      req_chan.mode      = ModeText;
      req_chan.data_byte = 8'h00;
      csr_wr_en   = 1'b0;
      csr_index   = CSR_COLUMN_SHIFT;
      csr_wr_data = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      configure(10'd999, 1'b0, 10'd24);
      foreach (Opening[k]) send_char(Opening[k]);
      drain(6);
      configure(10'd0, 1'b0, 10'd24);
      send_char({ModeText, CH_CR});
      drain(6);
      configure(10'd1023, 1'b0, 10'd24);   // saturates to the widest column
      send_char({ModeText, CH_CR});

      // count up to the page size without tripping the scroll flag
      drain(6);
      configure(10'd5, 1'b1, 10'd3);
      repeat (3) send_char({ModeText, CH_CR});
      drain(6);
      configure(10'd5, 1'b1, 10'd0);
      send_char({ModeText, CH_CR});
      drain(6);
      configure(10'd5, 1'b0, 10'd0);       // flag kept, but no marking
      send_char({ModeText, CH_CR});
      drain(6);
      configure(10'd5, 1'b1, 10'd0);
      send_char({ModeText, CH_CR});

      for (int p = 0; p < 7; p++) begin
         drain(6);
         col  = p[0] ? 10'($urandom_range(1023)) : ColumnMarks[$urandom_range(7)];
         page = (p == 1) ? 10'd1023 : ((p == 3) ? 10'd0 : 10'($urandom_range(1, 1023)));
         configure(col, 1'($urandom_range(1)), page);
         sender_steady   = (p == 2 || p == 4);
         receiver_steady = (p == 4);
         if (p == 2) stall_asks++;
         for (int k = 0; k < 40; k++) begin
            if (p == 5 && k == 20) drain(0);
            send_char(random_char());
         end
      end
      sender_steady   = 1'b0;
      receiver_steady = 1'b0;
      drain(10);

      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("tb_cp437_to_utf8_terminal_stream_unit: PASS");
      else
         $display("tb_cp437_to_utf8_terminal_stream_unit: FAIL");
      $finish;
   end

endmodule
